>>> rtl/text_cursor_glyph_renderer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text cursor glyph renderer.
// Simulation builds get concurrent checks; synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef TEXT_CURSOR_GLYPH_RENDERER_UNIT_ASSERT_SVH
`define TEXT_CURSOR_GLYPH_RENDERER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define TCGR_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

`define TCGR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TCGR_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define TCGR_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text cursor glyph renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_CURSOR = 2'd1;
    localparam logic [1:0] REQ_FONT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam int FONT_COLS = 5;

    localparam logic [3:0] SIZE_RESET = 4'd1;
    localparam logic [15:0] TEXT_COLOR_RESET = 16'hFFFF;
    localparam logic [15:0] BG_COLOR_RESET = 16'h0000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [8:0]  new_x;
        logic [8:0]  new_y;
        logic [10:0] font_index;
        logic [7:0]  font_byte;
    } t_req_item;

    typedef struct packed {
        logic [8:0]  rect_x;
        logic [8:0]  rect_y;
        logic [3:0]  rect_side;
        logic [15:0] rect_color;
        logic        last;
    } t_fill_item;

    typedef struct packed {
        logic set_cur;
        logic font_wr;
        logic newline;
        logic latch_code;
        logic wrap_col;
        logic wrap_row;
        logic prep;
        logic draw;
        logic step;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last_fill;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer that decodes requests and steps the datapath through the cursor
// wrap, glyph fetch and the 48 fill transfers of a character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcgr_ctrl
    import tcgr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_req_item i_req,
    output logic           o_in_ready,
    input  wire t_dp_sts   i_sts,
    output t_dp_cmd        o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WRAP_COL = 3'd1;
    localparam logic [2:0] ST_WRAP_ROW = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DRAW = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_req.req_type)
                        REQ_CURSOR: o_cmd.set_cur = 1'b1;
                        REQ_FONT: o_cmd.font_wr = 1'b1;
                        REQ_CHAR: begin
                            if (i_req.char_code == NEWLINE_CODE) begin
                                o_cmd.newline = 1'b1;
                            end else begin
                                o_cmd.latch_code = 1'b1;
                                n_state = ST_WRAP_COL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WRAP_COL: begin
                o_cmd.wrap_col = 1'b1;
                n_state = ST_WRAP_ROW;
            end
            ST_WRAP_ROW: begin
                o_cmd.wrap_row = 1'b1;
                n_state = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = ST_DRAW;
            end
            ST_DRAW: begin
                o_cmd.draw = 1'b1;
                o_cmd.step = i_sts.out_free;
                if (i_sts.out_free && i_sts.last_fill) begin
                    o_cmd.advance = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tcgr_dp.sv
// ----------------------------------------------------------------------------
// tcgr_dp
// Datapath: configuration registers, cursor, font store, glyph column and
// row counters, fill coordinate accumulators and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcgr_dp
    import tcgr_pkg::*;
#(
    parameter int DISPLAY_WIDTH = 480,
    parameter int DISPLAY_HEIGHT = 320,
    parameter int GLYPH_COUNT = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire t_req_item             i_req,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_fill_item                 o_out_data
);

    localparam int FONT_DEPTH = GLYPH_COUNT * FONT_COLS;
    localparam int AW = $clog2(FONT_DEPTH);
    localparam int CW = $clog2(DISPLAY_WIDTH + 512);
    localparam int RW = $clog2(DISPLAY_HEIGHT + 512);
    localparam logic [CW:0] W_LIM = (CW + 1)'(DISPLAY_WIDTH);
    localparam logic [RW:0] H_LIM = (RW + 1)'(DISPLAY_HEIGHT);
    localparam logic [8:0] GLYPH_LIM = 9'(GLYPH_COUNT);
    localparam logic [10:0] DEPTH_LIM = 11'(FONT_DEPTH);
    localparam logic [2:0] LAST_COL = 3'(FONT_COLS);
    localparam logic [2:0] LAST_ROW = 3'd7;

    logic [3:0]  r_size;
    logic [15:0] r_fg;
    logic [15:0] r_bg;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [7:0]  r_font [FONT_DEPTH];
    logic [7:0]  r_mem_q;
    logic [AW-1:0] r_base;
    logic        r_glyph_ok;
    logic [2:0]  r_i;
    logic [2:0]  r_j;
    logic [8:0]  r_x;
    logic [8:0]  r_y;
    logic [7:0]  r_bits;
    logic        r_out_valid;
    t_fill_item  r_out;

    logic [3:0]  s;
    logic [6:0]  s7;
    logic [6:0]  s8;
    logic [RW:0] row_sum;
    logic [RW-1:0] row_dn;
    logic [CW:0] col_end;
    logic [RW:0] row_end;
    logic [2:0]  rd_col;
    logic [AW-1:0] rd_addr;
    logic        col_last_row;

    assign s = (r_size == 4'd0) ? 4'd1 : r_size;
    assign s8 = {s, 3'b000};
    assign s7 = s8 - {3'b000, s};
    assign row_sum = {1'b0, r_row} + (RW + 1)'(s8);
    assign row_dn = (row_sum > H_LIM) ? RW'(DISPLAY_HEIGHT) : row_sum[RW-1:0];
    assign col_end = {1'b0, r_col} + (CW + 1)'(s7);
    assign row_end = {1'b0, r_row} + (RW + 1)'(s7);
    assign rd_col = i_cmd.draw ? (r_i + 3'd1) : r_i;
    assign rd_addr = r_base + AW'(rd_col);
    assign col_last_row = (r_j == LAST_ROW);

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.last_fill = (r_i == LAST_COL) && col_last_row;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_fg <= TEXT_COLOR_RESET;
            r_bg <= BG_COLOR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEXT_SIZE: r_size <= i_cfg_data[3:0];
                CFG_TEXT_COLOR: r_fg <= i_cfg_data;
                CFG_BG_COLOR: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            priority if (i_cmd.set_cur) begin
                r_col <= CW'(i_req.new_x);
                r_row <= RW'(i_req.new_y);
            end else if (i_cmd.newline) begin
                r_col <= '0;
                r_row <= row_dn;
            end else if (i_cmd.wrap_col) begin
                if (col_end > W_LIM) begin
                    r_col <= '0;
                    r_row <= row_dn;
                end
            end else if (i_cmd.wrap_row) begin
                if (row_end > H_LIM) begin
                    r_row <= '0;
                end
            end else if (i_cmd.advance) begin
                r_col <= col_end[CW-1:0];
            end else begin
                r_col <= r_col;
                r_row <= r_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.font_wr && (i_req.font_index < DEPTH_LIM)) begin
            r_font[i_req.font_index[AW-1:0]] <= i_req.font_byte;
        end
        r_mem_q <= r_font[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_code) begin
            r_base <= AW'({3'b000, i_req.char_code} + {1'b0, i_req.char_code, 2'b00});
            r_glyph_ok <= ({1'b0, i_req.char_code} < GLYPH_LIM);
            r_i <= '0;
        end else if (i_cmd.prep) begin
            r_j <= '0;
            r_x <= r_col[8:0];
            r_y <= r_row[8:0] + {2'b00, s7};
            r_bits <= r_glyph_ok ? r_mem_q : 8'd0;
        end else if (i_cmd.step) begin
            r_out.rect_x <= r_x;
            r_out.rect_y <= r_y;
            r_out.rect_side <= s;
            r_out.rect_color <= r_bits[r_j] ? r_fg : r_bg;
            r_out.last <= o_sts.last_fill;
            if (col_last_row) begin
                r_j <= '0;
                r_i <= r_i + 3'd1;
                r_x <= r_x + {5'b00000, s};
                r_y <= r_row[8:0] + {2'b00, s7};
                r_bits <= (r_glyph_ok && (r_i < LAST_COL - 3'd1)) ? r_mem_q : 8'd0;
            end else begin
                r_j <= r_j + 3'd1;
                r_y <= r_y - {5'b00000, s};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/text_cursor_glyph_renderer_unit.sv
// A cursor, set-cursor or font-load request, and a newline, is handled in the idle state. A character
// passes through the request, then column wrap, row wrap and glyph fetch, then 48 fill transfers
// at one per cycle while the sink does not stall.
// Synchronous active-low reset restores cursor 0,0, size 1, white text on black;
// the font store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer_unit
// Text console that turns character requests into glyph cell fill commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_cursor_glyph_renderer_unit_assert.svh"

module text_cursor_glyph_renderer_unit
    import tcgr_pkg::*;
#(
    parameter int DISPLAY_WIDTH = 480,
    parameter int DISPLAY_HEIGHT = 320,
    parameter int GLYPH_COUNT = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_req_item             i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_fill_item                 o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    tcgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req      (i_in_data),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcgr_dp #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .GLYPH_COUNT    (GLYPH_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `TCGR_ASSERT_IMPLIES(a_step_into_free_slot, i_clk, i_rst_n, cmd.step, sts.out_free)
    `TCGR_ASSERT_NEXT(a_last_fill_frees_input, i_clk, i_rst_n,
        cmd.step && sts.last_fill, o_in_ready && o_out_valid && o_out_data.last)
    `TCGR_ASSERT_IMPLIES(a_ready_only_when_not_drawing, i_clk, i_rst_n, o_in_ready, !cmd.draw)
    `TCGR_ASSERT_IMPLIES(a_fill_side_nonzero, i_clk, i_rst_n, o_out_valid,
        o_out_data.rect_side != 4'd0)

endmodule

`default_nettype wire

>>> tb/glyph_fill_monitor.sv
// ----------------------------------------------------------------------------
// glyph_fill_monitor
// Watches the request, fill and register channels of the glyph renderer,
// keeps its own cursor, font and register state, works out the fills that
// each accepted request must produce and compares every fill transfer with
// the oldest one still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_fill_monitor
    import tcgr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_req_item             i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_fill_item            i_out_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_fill_count
);

    localparam int DISPLAY_WIDTH = 480;
    localparam int DISPLAY_HEIGHT = 320;
    localparam int GLYPH_COUNT = 256;
    localparam int FONT_DEPTH = GLYPH_COUNT * FONT_COLS;
    localparam int REPORT_LIMIT = 10;

    logic [3:0]  size_reg;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    int          cur_col;
    int          cur_row;
    logic [7:0]  glyph_rom [FONT_DEPTH];
    t_fill_item  expected_fills [$];
    int          mismatch_count = 0;
    int          fills_seen = 0;

    task automatic move_down(input int s);
        cur_row = (cur_row + 8 * s > DISPLAY_HEIGHT) ? DISPLAY_HEIGHT : cur_row + 8 * s;
    endtask

    task automatic render_request(input t_req_item r);
        int         s;
        int         xlim;
        int         ylim;
        int         n;
        logic [7:0] column_bits;
        t_fill_item f;
        case (r.req_type)
            REQ_CURSOR: begin
                cur_col = r.new_x;
                cur_row = r.new_y;
            end
            REQ_FONT: begin
                if (int'(r.font_index) < FONT_DEPTH) begin
                    glyph_rom[r.font_index] = r.font_byte;
                end
            end
            REQ_CHAR: begin
                s = (size_reg == 4'd0) ? 1 : int'(size_reg);
                xlim = DISPLAY_WIDTH - 7 * s;
                ylim = DISPLAY_HEIGHT - 7 * s;
                if (r.char_code == NEWLINE_CODE) begin
                    cur_col = 0;
                    move_down(s);
                end else begin
                    if (cur_col > xlim) begin
                        cur_col = 0;
                        move_down(s);
                    end
                    if (cur_row > ylim) begin
                        cur_row = 0;
                    end
                    n = 0;
                    for (int i = 0; i < 6; i++) begin
                        column_bits = 8'h00;
                        if (i < FONT_COLS && int'(r.char_code) < GLYPH_COUNT) begin
                            column_bits = glyph_rom[int'(r.char_code) * FONT_COLS + i];
                        end
                        for (int j = 0; j < 8; j++) begin
                            f.rect_x = 9'(cur_col + i * s);
                            f.rect_y = 9'(cur_row + (7 - j) * s);
                            f.rect_side = 4'(s);
                            f.rect_color = column_bits[j] ? fg_color : bg_color;
                            f.last = (n == 47);
                            expected_fills.push_back(f);
                            n++;
                        end
                    end
                    cur_col = cur_col + 7 * s;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_fill(input t_fill_item got);
        t_fill_item want;
        if (expected_fills.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("Unexpected fill transfer: x=%0d y=%0d side=%0d color=%h last=%0d",
                         got.rect_x, got.rect_y, got.rect_side, got.rect_color, got.last);
            end
        end else begin
            want = expected_fills.pop_front();
            if (got.rect_x !== want.rect_x || got.rect_y !== want.rect_y ||
                got.rect_side !== want.rect_side || got.rect_color !== want.rect_color ||
                got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Fill mismatch: expected x=%0d y=%0d side=%0d color=%h last=%0d",
                             want.rect_x, want.rect_y, want.rect_side, want.rect_color,
                             want.last);
                    $display("               actual   x=%0d y=%0d side=%0d color=%h last=%0d",
                             got.rect_x, got.rect_y, got.rect_side, got.rect_color, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg = SIZE_RESET;
            fg_color = TEXT_COLOR_RESET;
            bg_color = BG_COLOR_RESET;
            cur_col = 0;
            cur_row = 0;
            for (int k = 0; k < FONT_DEPTH; k++) begin
                glyph_rom[k] = 8'h00;
            end
            expected_fills.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                fills_seen++;
                compare_fill(i_out_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEXT_SIZE:  size_reg = i_cfg_data[3:0];
                    CFG_TEXT_COLOR: fg_color = i_cfg_data;
                    CFG_BG_COLOR:   bg_color = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                render_request(i_in_data);
            end
        end
        o_pending <= expected_fills.size();
        o_fail_count <= mismatch_count;
        o_fill_count <= fills_seen;
    end

endmodule

>>> tb/text_cursor_glyph_renderer_unit_test.sv
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer_unit_test
// Drives the glyph renderer with a short directed sequence for the cursor
// wrap, row saturation, font bounds and unknown request cases, then with
// random text, cursor moves, font loads and unknown requests under several
// size and color settings, while both channels idle at random outside one
// calm phase. The fill monitor predicts and compares every fill transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_cursor_glyph_renderer_unit_test;
    import tcgr_pkg::*;

    localparam int GLYPH_TOTAL = 256;
    localparam int FONT_DEPTH = GLYPH_TOTAL * FONT_COLS;
    localparam int QUIET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 71;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_req_item             in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_fill_item            out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int fill_count;
    int cycle_count = 0;
    bit calm = 1'b0;

    bit font_written [FONT_DEPTH];
    bit glyph_listed [GLYPH_TOTAL];
    int usable_codes [$];

    int n_glyphs = 0;
    int n_newlines = 0;
    int n_cursor = 0;
    int n_font = 0;
    int n_unknown = 0;
    int n_reg_writes = 0;

    text_cursor_glyph_renderer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    glyph_fill_monitor fill_mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_fill_count (fill_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d fills outstanding", cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_req_item noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_req_item)-1:0];
    endfunction

    task automatic note_request(input t_req_item r);
        int code;
        bit whole;
        case (r.req_type)
            REQ_CHAR: begin
                if (r.char_code == NEWLINE_CODE) n_newlines++;
                else n_glyphs++;
            end
            REQ_CURSOR: n_cursor++;
            REQ_FONT: begin
                n_font++;
                if (int'(r.font_index) < FONT_DEPTH) begin
                    font_written[r.font_index] = 1'b1;
                    code = int'(r.font_index) / FONT_COLS;
                    whole = 1'b1;
                    for (int i = 0; i < FONT_COLS; i++) begin
                        whole &= font_written[code * FONT_COLS + i];
                    end
                    if (whole && !glyph_listed[code]) begin
                        glyph_listed[code] = 1'b1;
                        usable_codes.push_back(code);
                    end
                end
            end
            default: n_unknown++;
        endcase
    endtask

    task automatic send_req(input t_req_item r);
        if (!calm && $urandom_range(0, 99) < 5) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
        while (!calm && $urandom_range(0, 99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        note_request(r);
    endtask

    task automatic char_req(input logic [7:0] code);
        t_req_item r;
        r = noise_item();
        r.req_type = REQ_CHAR;
        r.char_code = code;
        send_req(r);
    endtask

    task automatic cursor_req(input logic [8:0] x, input logic [8:0] y);
        t_req_item r;
        r = noise_item();
        r.req_type = REQ_CURSOR;
        r.new_x = x;
        r.new_y = y;
        send_req(r);
    endtask

    task automatic font_req(input logic [10:0] index, input logic [7:0] value);
        t_req_item r;
        r = noise_item();
        r.req_type = REQ_FONT;
        r.font_index = index;
        r.font_byte = value;
        send_req(r);
    endtask

    task automatic glyph_load(input int code);
        for (int i = 0; i < FONT_COLS; i++) begin
            font_req(11'(code * FONT_COLS + i), 8'($urandom));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        n_reg_writes++;
    endtask

    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic random_step(output int sent);
        int pick;
        t_req_item r;
        pick = $urandom_range(0, 99);
        sent = 1;
        if (pick < 6) begin
            glyph_load($urandom_range(0, GLYPH_TOTAL - 1));
            sent = FONT_COLS;
        end else if (pick < 13) begin
            cursor_req(9'($urandom), 9'($urandom));
        end else if (pick < 20) begin
            char_req(NEWLINE_CODE);
        end else if (pick < 24) begin
            font_req(11'($urandom), 8'($urandom));
        end else if (pick < 27) begin
            r = noise_item();
            r.req_type = REQ_UNUSED;
            send_req(r);
        end else begin
            char_req(8'(usable_codes[$urandom_range(0, usable_codes.size() - 1)]));
        end
    endtask

    task automatic set_phase_regs(input int phase);
        logic [3:0]  sizes [PHASE_COUNT] = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd5};
        logic [15:0] size_word;
        logic [15:0] fg;
        logic [15:0] bg;
        size_word = 16'($urandom);
        size_word[3:0] = sizes[phase];
        fg = 16'($urandom);
        bg = 16'($urandom);
        if (phase == 1) begin
            fg = 16'hFFFF;
            bg = 16'h0000;
        end else if (phase == 2) begin
            fg = 16'h0000;
            bg = 16'hFFFF;
        end
        write_reg(CFG_TEXT_SIZE, size_word);
        write_reg(CFG_TEXT_COLOR, fg);
        write_reg(CFG_BG_COLOR, bg);
        if (phase == 0) begin
            write_reg(CFG_UNUSED, 16'($urandom));
        end
    endtask

    initial begin
        int sent;
        int done;
        t_req_item r;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        font_req(11'(0), 8'hFF);
        font_req(11'(1), 8'h00);
        font_req(11'(2), 8'hA5);
        font_req(11'(3), 8'h5A);
        font_req(11'(4), 8'h81);
        glyph_load(255);
        char_req(8'h00);
        char_req(8'hFF);
        font_req(11'h7FF, 8'($urandom));
        font_req(11'(FONT_DEPTH), 8'($urandom));
        r = noise_item();
        r.req_type = REQ_UNUSED;
        send_req(r);
        cursor_req(9'd473, 9'd313);
        char_req(8'hFF);
        char_req(8'h00);
        cursor_req(9'h1FF, 9'h1FF);
        char_req(8'h00);
        cursor_req(9'd0, 9'd316);
        char_req(NEWLINE_CODE);
        char_req(8'hFF);
        char_req(NEWLINE_CODE);
        wait_for_quiet();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_phase_regs(phase);
            calm <= (phase == 2);
            done = 0;
            while (done < PHASE_ITEMS) begin
                random_step(sent);
                done += sent;
                if (phase == 4 && done >= PHASE_ITEMS / 2 && done - sent < PHASE_ITEMS / 2) begin
                    wait_for_quiet();
                end
            end
            wait_for_quiet();
            calm <= 1'b0;
        end

        $display("Sent %0d glyphs, %0d newlines, %0d cursor moves, %0d font loads, %0d unknown",
                 n_glyphs, n_newlines, n_cursor, n_font, n_unknown);
        $display("requests with %0d register writes; %0d fill transfers compared, %0d mismatched",
                 n_reg_writes, fill_count, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_ctrl.sv
rtl/tcgr_dp.sv
rtl/text_cursor_glyph_renderer_unit.sv
tb/glyph_fill_monitor.sv
tb/text_cursor_glyph_renderer_unit_test.sv
